@@ rtl/rbs_pkg.sv @@
// shared types, constants and register codes for the ray/box slab test
package rbs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_BITS  = 32;
    localparam int NUM_AXES   = 3;
    localparam int NUM_CFG    = 6;
    localparam int DATA_W     = (WORD_BITS > 32) ? 64 : 32;
    localparam int ADDR_LSB   = (WORD_BITS > 32) ? 3 : 2;
    localparam int ADDR_W     = ADDR_LSB + 3;
    // dividend width, leading remainder width, compare width for the saturation test
    localparam int NUM_W      = WORD_BITS + 1 + FRAC_BITS;
    localparam int R0_W       = NUM_W - (WORD_BITS - 1);
    localparam int CMP_W      = (R0_W > WORD_BITS) ? R0_W : WORD_BITS;
    localparam int DIV_STEPS  = WORD_BITS - 1;
    localparam int NUM_STAGES = DIV_STEPS + 3 + NUM_AXES;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef enum logic [2:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        word_t origin_x;
        word_t origin_y;
        word_t origin_z;
        word_t dir_x;
        word_t dir_y;
        word_t dir_z;
        word_t t_min;
        word_t t_max;
    } ray_in_t;

    typedef struct packed {
        logic  hit;
        word_t t_near;
        word_t t_far;
    } ray_out_t;

    typedef struct packed {
        logic                                  empty;
        word_t                                 t_min;
        word_t                                 t_max;
        logic [NUM_AXES-1:0]                   par;
        logic [NUM_AXES-1:0]                   outside;
        logic [NUM_AXES-1:0][WORD_BITS:0]      dlo;
        logic [NUM_AXES-1:0][WORD_BITS:0]      dhi;
        logic [NUM_AXES-1:0][WORD_BITS-1:0]    dir;
    } prep_pkt_t;

    typedef struct packed {
        logic                 neg;
        logic                 sat;
        logic [WORD_BITS-1:0] ud;
        logic [WORD_BITS-1:0] r;
        logic [WORD_BITS-2:0] nbits;
        logic [WORD_BITS-2:0] q;
    } lane_t;

    typedef struct packed {
        logic  par;
        logic  outside;
        lane_t lo;
        lane_t hi;
    } div_axis_t;

    typedef struct packed {
        logic                           empty;
        word_t                          t_min;
        word_t                          t_max;
        div_axis_t [NUM_AXES-1:0]       ax;
    } div_pkt_t;

    typedef struct packed {
        logic  par;
        logic  outside;
        word_t a;
        word_t b;
    } fin_axis_t;

    typedef struct packed {
        logic                     done;
        logic                     hit;
        word_t                    tn;
        word_t                    tf;
        fin_axis_t [NUM_AXES-1:0] ax;
    } axis_pkt_t;

endpackage

@@ rtl/rbs_prep.sv @@
// two front stages: slab differences and parallel tests, then magnitudes and divider setup
module rbs_prep
    import rbs_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  ray_in_t                            in_data,
    input  logic [NUM_AXES-1:0][WORD_BITS-1:0] box_min,
    input  logic [NUM_AXES-1:0][WORD_BITS-1:0] box_max,
    input  logic                               en_a,
    input  logic                               en_b,
    output logic                               valid_a,
    output logic                               valid_b,
    output div_pkt_t                           pkt_out
);

    prep_pkt_t a_next, a_reg;
    div_pkt_t  b_next, b_reg;
    logic      valid_a_reg, valid_b_reg;
    logic [NUM_AXES-1:0][WORD_BITS-1:0] org;
    logic [NUM_AXES-1:0][WORD_BITS-1:0] dir;

    function automatic lane_t mk_lane(logic [WORD_BITS:0] d, logic [WORD_BITS-1:0] dv);
        lane_t              l;
        logic [WORD_BITS:0] un;
        logic [NUM_W-1:0]   num;
        logic [R0_W-1:0]    r0;
        l.neg   = d[WORD_BITS] ^ dv[WORD_BITS-1];
        un      = d[WORD_BITS] ? (~d + 1'b1) : d;
        l.ud    = dv[WORD_BITS-1] ? (~dv + 1'b1) : dv;
        num     = {un, {FRAC_BITS{1'b0}}};
        r0      = num[NUM_W-1 -: R0_W];
        // quotient would reach 2^(W-1): saturate
        l.sat   = CMP_W'(r0) >= CMP_W'(l.ud);
        l.r     = WORD_BITS'(r0);
        l.nbits = num[WORD_BITS-2:0];
        l.q     = '0;
        return l;
    endfunction

    assign org = {in_data.origin_z, in_data.origin_y, in_data.origin_x};
    assign dir = {in_data.dir_z, in_data.dir_y, in_data.dir_x};

    always_comb
    begin
        a_next.empty = 1'b0;
        a_next.t_min = in_data.t_min;
        a_next.t_max = in_data.t_max;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if ($signed(box_min[i]) > $signed(box_max[i]))
            begin
                a_next.empty = 1'b1;
            end
            a_next.par[i]     = (dir[i] == '0);
            a_next.outside[i] = ($signed(org[i]) < $signed(box_min[i])) ||
                                ($signed(org[i]) > $signed(box_max[i]));
            a_next.dlo[i]     = {box_min[i][WORD_BITS-1], box_min[i]} -
                                {org[i][WORD_BITS-1], org[i]};
            a_next.dhi[i]     = {box_max[i][WORD_BITS-1], box_max[i]} -
                                {org[i][WORD_BITS-1], org[i]};
            a_next.dir[i]     = dir[i];
        end
    end

    always_comb
    begin
        b_next.empty = a_reg.empty;
        b_next.t_min = a_reg.t_min;
        b_next.t_max = a_reg.t_max;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            b_next.ax[i].par     = a_reg.par[i];
            b_next.ax[i].outside = a_reg.outside[i];
            b_next.ax[i].lo      = mk_lane(a_reg.dlo[i], a_reg.dir[i]);
            b_next.ax[i].hi      = mk_lane(a_reg.dhi[i], a_reg.dir[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (en_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_reg <= a_next;
        end
        if (en_b)
        begin
            b_reg <= b_next;
        end
    end

    assign valid_a = valid_a_reg;
    assign valid_b = valid_b_reg;
    assign pkt_out = b_reg;

endmodule

@@ rtl/rbs_div_cell.sv @@
// one restoring division step for all six slab quotients of a ray
module rbs_div_cell
    import rbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     valid_in,
    input  div_pkt_t pkt_in,
    output logic     valid_out,
    output div_pkt_t pkt_out
);

    div_pkt_t pkt_next, pkt_reg;
    logic     valid_reg;

    function automatic lane_t div_step(lane_t l);
        lane_t              o;
        logic [WORD_BITS:0] t;
        logic [WORD_BITS:0] diff;
        logic               ge;
        o       = l;
        t       = {l.r, l.nbits[WORD_BITS-2]};
        diff    = t - {1'b0, l.ud};
        ge      = t >= {1'b0, l.ud};
        o.r     = ge ? diff[WORD_BITS-1:0] : t[WORD_BITS-1:0];
        o.nbits = {l.nbits[WORD_BITS-3:0], 1'b0};
        o.q     = {l.q[WORD_BITS-3:0], ge};
        return o;
    endfunction

    always_comb
    begin
        pkt_next = pkt_in;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            pkt_next.ax[i].lo = div_step(pkt_in.ax[i].lo);
            pkt_next.ax[i].hi = div_step(pkt_in.ax[i].hi);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pkt_reg <= pkt_next;
        end
    end

    assign valid_out = valid_reg;
    assign pkt_out   = pkt_reg;

endmodule

@@ rtl/rbs_sign.sv @@
// saturation and sign of the quotients, start values of the running window
module rbs_sign
    import rbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      valid_in,
    input  div_pkt_t  pkt_in,
    output logic      valid_out,
    output axis_pkt_t pkt_out
);

    axis_pkt_t pkt_next, pkt_reg;
    logic      valid_reg;

    function automatic word_t fix(lane_t l);
        logic [WORD_BITS-1:0] mag;
        logic [WORD_BITS-1:0] res;
        mag = l.sat ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, l.q};
        if (mag == '0)
        begin
            res = '0;
        end
        else if (l.neg)
        begin
            res = ~mag + 1'b1;
        end
        else if (mag[WORD_BITS-1])
        begin
            res = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        else
        begin
            res = mag;
        end
        return word_t'(res);
    endfunction

    always_comb
    begin
        // empty box: finished miss from the start
        pkt_next.done = pkt_in.empty;
        pkt_next.hit  = !pkt_in.empty;
        pkt_next.tn   = pkt_in.t_min;
        pkt_next.tf   = pkt_in.t_max;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            pkt_next.ax[i].par     = pkt_in.ax[i].par;
            pkt_next.ax[i].outside = pkt_in.ax[i].outside;
            pkt_next.ax[i].a       = fix(pkt_in.ax[i].lo);
            pkt_next.ax[i].b       = fix(pkt_in.ax[i].hi);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pkt_reg <= pkt_next;
        end
    end

    assign valid_out = valid_reg;
    assign pkt_out   = pkt_reg;

endmodule

@@ rtl/rbs_axis_cell.sv @@
// narrows the running window by the axis at slot 0, then rotates the next axis in
module rbs_axis_cell
    import rbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      valid_in,
    input  axis_pkt_t pkt_in,
    output logic      valid_out,
    output axis_pkt_t pkt_out
);

    axis_pkt_t pkt_next, pkt_reg;
    fin_axis_t cur;
    word_t     lo, hi, tn, tf;
    logic      valid_reg;

    assign cur = pkt_in.ax[0];

    always_comb
    begin
        pkt_next    = pkt_in;
        pkt_next.ax = {cur, pkt_in.ax[NUM_AXES-1:1]};
        lo = (cur.a > cur.b) ? cur.b : cur.a;
        hi = (cur.a > cur.b) ? cur.a : cur.b;
        tn = (lo > pkt_in.tn) ? lo : pkt_in.tn;
        tf = (hi < pkt_in.tf) ? hi : pkt_in.tf;
        if (!pkt_in.done)
        begin
            if (cur.par)
            begin
                if (cur.outside)
                begin
                    pkt_next.hit  = 1'b0;
                    pkt_next.done = 1'b1;
                end
            end
            else
            begin
                pkt_next.tn = tn;
                pkt_next.tf = tf;
                if (tn > tf)
                begin
                    pkt_next.hit  = 1'b0;
                    pkt_next.done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pkt_reg <= pkt_next;
        end
    end

    assign valid_out = valid_reg;
    assign pkt_out   = pkt_reg;

endmodule

@@ rtl/ray_box_slab_intersection.sv @@
// top level: box registers, stage chain and handshake of the slab test
//
//  channel   dir   handshake              payload
//  in        in    in_valid / in_ready    ray_in_t  origin, direction, window
//  out       out   out_valid / out_ready  ray_out_t hit, t_near, t_far
//  config    in    apb psel/penable       box bounds, 6 registers at 4*i
//
// one ray enters per cycle while in_ready is high; a ray passes the prep stages, the divider
// cells (one quotient bit per cycle unless stalled), the sign stage, then three axis cells
// every stage holds its ray until the next one frees, so bubbles fill on a stall
// reset clears the stage valid flags and sets all box bounds to zero
module ray_box_slab_intersection
    import rbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ray_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ray_out_t          out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [NUM_AXES-1:0][WORD_BITS-1:0] box_min_reg, box_max_reg;
    logic [NUM_STAGES-1:0] vld, rdy;
    div_pkt_t  div_pkt [DIV_STEPS+1];
    axis_pkt_t ax_pkt  [NUM_AXES+1];
    cfg_idx_t  idx;
    logic      wr;

    assign pready = 1'b1;
    assign idx    = cfg_idx_t'(paddr[ADDR_W-1:ADDR_LSB]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg <= '0;
            box_max_reg <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                CFG_BOX_MIN_X: box_min_reg[0] <= pwdata[WORD_BITS-1:0];
                CFG_BOX_MIN_Y: box_min_reg[1] <= pwdata[WORD_BITS-1:0];
                CFG_BOX_MIN_Z: box_min_reg[2] <= pwdata[WORD_BITS-1:0];
                CFG_BOX_MAX_X: box_max_reg[0] <= pwdata[WORD_BITS-1:0];
                CFG_BOX_MAX_Y: box_max_reg[1] <= pwdata[WORD_BITS-1:0];
                CFG_BOX_MAX_Z: box_max_reg[2] <= pwdata[WORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            CFG_BOX_MIN_X: prdata = DATA_W'(box_min_reg[0]);
            CFG_BOX_MIN_Y: prdata = DATA_W'(box_min_reg[1]);
            CFG_BOX_MIN_Z: prdata = DATA_W'(box_min_reg[2]);
            CFG_BOX_MAX_X: prdata = DATA_W'(box_max_reg[0]);
            CFG_BOX_MAX_Y: prdata = DATA_W'(box_max_reg[1]);
            CFG_BOX_MAX_Z: prdata = DATA_W'(box_max_reg[2]);
            default:       prdata = '0;
        endcase
    end

    // a stage loads when it is empty or its successor loads
    assign rdy[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (genvar k = 0; k < NUM_STAGES - 1; k++)
    begin : g_rdy
        assign rdy[k] = !vld[k] || rdy[k+1];
    end

    assign in_ready = rdy[0];

    rbs_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .box_min  (box_min_reg),
        .box_max  (box_max_reg),
        .en_a     (rdy[0]),
        .en_b     (rdy[1]),
        .valid_a  (vld[0]),
        .valid_b  (vld[1]),
        .pkt_out  (div_pkt[0])
    );

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        rbs_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (rdy[k+2]),
            .valid_in  (vld[k+1]),
            .pkt_in    (div_pkt[k]),
            .valid_out (vld[k+2]),
            .pkt_out   (div_pkt[k+1])
        );
    end

    rbs_sign u_sign (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (rdy[DIV_STEPS+2]),
        .valid_in  (vld[DIV_STEPS+1]),
        .pkt_in    (div_pkt[DIV_STEPS]),
        .valid_out (vld[DIV_STEPS+2]),
        .pkt_out   (ax_pkt[0])
    );

    for (genvar j = 0; j < NUM_AXES; j++)
    begin : g_axis
        rbs_axis_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (rdy[DIV_STEPS+3+j]),
            .valid_in  (vld[DIV_STEPS+2+j]),
            .pkt_in    (ax_pkt[j]),
            .valid_out (vld[DIV_STEPS+3+j]),
            .pkt_out   (ax_pkt[j+1])
        );
    end

    assign out_valid       = vld[NUM_STAGES-1];
    assign out_data.hit    = ax_pkt[NUM_AXES].hit;
    assign out_data.t_near = ax_pkt[NUM_AXES].tn;
    assign out_data.t_far  = ax_pkt[NUM_AXES].tf;

endmodule

@@ rtl/rbs_checker.sv @@
// port-level checks on the slab test, bound to the top level
module rbs_checker
    import rbs_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input ray_out_t out_data,
    input logic     pready
);

    // an empty last stage means every stage can load
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low while output empty");

    // a taken result frees the last stage, so the whole chain can load
    a_ready_on_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while out_ready high");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped or changed under stall");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind ray_box_slab_intersection rbs_checker u_rbs_checker (.*);
